/* hdl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Holds the controller state type, the result beat record and the fixed
// cell codes that more than one module of the console uses.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CELL_W  = 16;
    localparam int CODE_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;

    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0F20;
    localparam logic [CELL_W-1:0] FILL_CELL    = 16'h0020;
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
    } t_result;

endpackage

/* hdl/tcw_screen_ram.sv */
// ----------------------------------------------------------------------------
// tcw_screen_ram: character cell store
// Simple dual-port synchronous memory with one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] o_rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl: console sequencer
// Keeps the cursor and the ring offset of the screen, turns requests into
// memory accesses, runs the clearing pass and the row fill of a scroll.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_attr,
    input  logic                        i_in_valid,
    output logic                        o_busy,
    input  logic                        i_req_type,
    input  logic [tcw_pkg::CODE_W-1:0]  i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0] i_cell_index,
    output logic                        o_res_valid,
    output tcw_pkg::t_result            o_res,
    input  logic                        i_res_take,
    output logic                        o_wr_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0] o_wr_addr,
    output logic [tcw_pkg::CELL_W-1:0]  o_wr_data,
    output logic                        o_rd_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0] o_rd_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_rd_data
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int SW    = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

    t_state r_state, n_state;

    logic [CW-1:0] r_x, n_x;
    logic [RW-1:0] r_y, n_y;
    logic [AW-1:0] r_lin, n_lin;
    logic [AW-1:0] r_row_lin, n_row_lin;
    logic [AW-1:0] r_base, n_base;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_fill_addr, n_fill_addr;
    logic [CW-1:0] r_fill_cnt, n_fill_cnt;
    logic          r_rd_ok, n_rd_ok;
    t_result       r_res, n_res;

    logic          accept;
    logic          is_write;
    logic          is_nl;
    logic [CW:0]   x_inc;
    logic          wrap;
    logic          nl_event;
    logic          last_row;
    logic          clr_last;
    logic          fill_last;
    logic [AW:0]   sum_c;
    logic [AW:0]   phys_c;
    logic [SW-1:0] idx_ext;
    logic [SW-1:0] sum_r;
    logic [SW-1:0] phys_r;
    logic          in_range;
    logic [AW:0]   base_inc;
    logic [CW+COL_W-1:0] col_ext;
    logic [RW+ROW_W-1:0] row_ext;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign is_write = (i_req_type == REQ_WRITE);
    assign is_nl    = (i_char_code == NEWLINE_CODE);
    assign x_inc    = {1'b0, r_x} + (CW+1)'(1);
    assign wrap     = (x_inc == (CW+1)'(COLUMNS));
    assign nl_event = is_write && (is_nl || wrap);
    assign last_row = (r_y == RW'(ROWS - 1));
    assign clr_last  = (r_clr_addr == AW'(CELLS - 1));
    assign fill_last = (r_fill_cnt == CW'(COLUMNS - 1));

    // Logical to physical address: the screen is a ring of rows whose top
    // row starts at r_base.
    assign sum_c  = {1'b0, r_lin} + {1'b0, r_base};
    assign phys_c = (sum_c >= (AW+1)'(CELLS)) ? (sum_c - (AW+1)'(CELLS)) : sum_c;

    assign idx_ext  = SW'(i_cell_index);
    assign in_range = (idx_ext < SW'(CELLS));
    assign sum_r    = idx_ext + SW'(r_base);
    assign phys_r   = (sum_r >= SW'(CELLS)) ? (sum_r - SW'(CELLS)) : sum_r;

    assign base_inc = {1'b0, r_base} + (AW+1)'(COLUMNS);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (!is_write) begin
                        n_state = S_READ;
                    end else if (nl_event && last_row) begin
                        n_state = S_SCROLL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_SCROLL: begin
                if (fill_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_x         = r_x;
        n_y         = r_y;
        n_lin       = r_lin;
        n_row_lin   = r_row_lin;
        n_base      = r_base;
        n_clr_addr  = r_clr_addr;
        n_fill_addr = r_fill_addr;
        n_fill_cnt  = r_fill_cnt;
        n_rd_ok     = r_rd_ok;
        n_res       = r_res;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_clr_addr;
        o_wr_data   = RESET_CELL;
        o_rd_en     = 1'b0;
        o_rd_addr   = phys_r[AW-1:0];
        col_ext     = '0;
        row_ext     = '0;

        case (r_state)
            S_CLEAR: begin
                o_wr_en    = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_res.cell_data = '0;
                    n_res.scrolled  = 1'b0;
                    if (!is_write) begin
                        o_rd_en = in_range;
                        n_rd_ok = in_range;
                    end else begin
                        if (!is_nl) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = phys_c[AW-1:0];
                            o_wr_data = {i_attr, i_char_code};
                        end
                        if (nl_event) begin
                            n_x = '0;
                            if (last_row) begin
                                n_lin          = r_row_lin;
                                n_base         = (base_inc == (AW+1)'(CELLS)) ? '0
                                                 : base_inc[AW-1:0];
                                n_fill_addr    = r_base;
                                n_fill_cnt     = '0;
                                n_res.scrolled = 1'b1;
                            end else begin
                                n_y       = r_y + RW'(1);
                                n_row_lin = r_row_lin + AW'(COLUMNS);
                                n_lin     = r_row_lin + AW'(COLUMNS);
                            end
                        end else begin
                            n_x   = x_inc[CW-1:0];
                            n_lin = r_lin + AW'(1);
                        end
                    end
                    col_ext          = {{COL_W{1'b0}}, n_x};
                    row_ext          = {{ROW_W{1'b0}}, n_y};
                    n_res.cursor_col = col_ext[COL_W-1:0];
                    n_res.cursor_row = row_ext[ROW_W-1:0];
                end
            end
            S_READ: begin
                n_res.cell_data = r_rd_ok ? i_rd_data : '0;
            end
            S_SCROLL: begin
                // The old top row becomes the new bottom row.
                o_wr_en     = 1'b1;
                o_wr_addr   = r_fill_addr;
                o_wr_data   = FILL_CELL;
                n_fill_addr = r_fill_addr + AW'(1);
                n_fill_cnt  = r_fill_cnt + CW'(1);
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_x        <= '0;
            r_y        <= '0;
            r_lin      <= '0;
            r_row_lin  <= '0;
            r_base     <= '0;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_x        <= n_x;
            r_y        <= n_y;
            r_lin      <= n_lin;
            r_row_lin  <= n_row_lin;
            r_base     <= n_base;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_addr <= n_fill_addr;
        r_fill_cnt  <= n_fill_cnt;
        r_rd_ok     <= n_rd_ok;
        r_res       <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

/* hdl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Screen store with cursor, line wrap, newline and scroll, plus a read
// port for scan-out of single cells.
// ----------------------------------------------------------------------------
// After reset the console runs a clearing pass over all COLUMNS*ROWS cells
// (2000 at the default size), writing a white space into every cell, and
// takes no request beat until it is done; the attribute register may be
// written during that time. A character or newline beat that does not scroll
// goes from idle straight to done, a cell read passes the read state first
// (the screen memory read port is registered), and a scrolling request then
// writes each new bottom-row cell through the single memory write port.
// Scrolling never copies the screen: the rows form a ring in memory and only
// the offset of the top row moves, so cell_index always addresses the screen
// as it appears. One request is in work at a time; a finished result sits in
// the output register while the next request is already being accepted.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [tcw_pkg::CODE_W-1:0]    i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   i_cell_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_data,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_row,
    output logic                          o_scrolled
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    // Attribute placed in every character cell that is written.
    logic [ATTR_W-1:0] r_attr;

    logic              res_valid;
    t_result           res;
    logic              res_take;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CELL_W-1:0] rd_data;

    // Output register: holds one result beat until the sink takes it.
    logic              r_out_valid, n_out_valid;
    t_result           r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attr       (r_attr),
        .i_in_valid   (i_in_valid),
        .o_busy       (o_in_stall),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The controller hands its result over whenever the output register is
    // empty or is being emptied in the same cycle.
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_data  = r_out.cell_data;
    assign o_cursor_col = r_out.cursor_col;
    assign o_cursor_row = r_out.cursor_row;
    assign o_scrolled   = r_out.scrolled;

endmodule

/* tb/text_console_writer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_test: self-checking testbench of the text console
// Request beats are queued by a stimulus process, driven by a clocked driver
// and predicted on acceptance by a cycle-free model of the screen, cursor and
// attribute register. A clocked monitor checks every result beat, field by
// field, against the oldest predicted result. Both sides idle at random.
// ----------------------------------------------------------------------------
module text_console_writer_test;

    import tcw_pkg::*;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Limit of the whole run in ns, after which the watchdog ends it.
    localparam longint RUN_LIMIT_NS = 2_000_000;

    typedef struct {
        logic               req_type;
        logic [CODE_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } request_beat_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero.
    // ------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [ATTR_W-1:0]  i_cfg_wr_data = '0;
    logic               i_in_valid    = 1'b0;
    logic               i_req_type    = REQ_WRITE;
    logic [CODE_W-1:0]  i_char_code   = '0;
    logic [INDEX_W-1:0] i_cell_index  = '0;
    logic               i_out_stall   = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [CELL_W-1:0]  o_cell_data;
    logic [COL_W-1:0]   o_cursor_col;
    logic [ROW_W-1:0]   o_cursor_row;
    logic               o_scrolled;

    always #1 i_clk = ~i_clk;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_char_code   (i_char_code),
        .i_cell_index  (i_cell_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_data   (o_cell_data),
        .o_cursor_col  (o_cursor_col),
        .o_cursor_row  (o_cursor_row),
        .o_scrolled    (o_scrolled)
    );

    // ------------------------------------------------------------------
    // Shared testbench state.
    // ------------------------------------------------------------------
    request_beat_t request_queue[$];     // beats waiting to be driven
    t_result       console_results[$];   // predicted results, oldest first
    int unsigned   idle_pct = 7;         // chance per cycle that a side idles
    int unsigned   mismatch_count = 0;

    // The console as the predictor sees it.
    logic [CELL_W-1:0] screen_image [CELL_COUNT];
    int unsigned       cursor_col_now;
    int unsigned       cursor_row_now;
    logic [ATTR_W-1:0] attribute_now;

    // ------------------------------------------------------------------
    // Predictor. A newline, or a write into the last column, moves the
    // cursor to the start of the next row; moving off the bottom row
    // shifts every row up by one and fills the new bottom row with spaces
    // of attribute zero, whatever the attribute register holds.
    // ------------------------------------------------------------------
    function automatic logic start_next_line();
        cursor_col_now = 0;
        cursor_row_now++;
        if (cursor_row_now < ROWS)
            return 1'b0;
        cursor_row_now = ROWS - 1;
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
            screen_image[i] = screen_image[i + COLUMNS];
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_image[i] = FILL_CELL;
        return 1'b1;
    endfunction

    function automatic t_result console_step(request_beat_t beat);
        t_result r;
        r = '0;
        if (beat.req_type == REQ_READ) begin
            // A read past the end of the screen returns zero.
            if (beat.cell_index < CELL_COUNT)
                r.cell_data = screen_image[beat.cell_index];
        end else if (beat.char_code == NEWLINE_CODE) begin
            r.scrolled = start_next_line();
        end else begin
            screen_image[cursor_row_now * COLUMNS + cursor_col_now] =
                {attribute_now, beat.char_code};
            cursor_col_now++;
            if (cursor_col_now >= COLUMNS)
                r.scrolled = start_next_line();
        end
        r.cursor_col = cursor_col_now[COL_W-1:0];
        r.cursor_row = cursor_row_now[ROW_W-1:0];
        return r;
    endfunction

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver. A beat is accepted on an edge where valid is high and stall
    // is low; it is predicted there and then. A new beat, or an idle
    // cycle, follows only once the current one has gone, so a stalled
    // payload never changes.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        request_beat_t next_beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                console_results.push_back(
                    console_step('{i_req_type, i_char_code, i_cell_index}));
            if (!i_in_valid || !o_in_stall) begin
                if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    next_beat    = request_queue.pop_front();
                    i_in_valid   <= 1'b1;
                    i_req_type   <= next_beat.req_type;
                    i_char_code  <= next_beat.char_code;
                    i_cell_index <= next_beat.cell_index;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each accepted result beat is checked against the oldest
    // prediction; the output stall is raised at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (console_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", o_cell_data, 0);
                end else begin
                    want = console_results.pop_front();
                    if (o_cell_data !== want.cell_data)
                        report_mismatch("cell_data", o_cell_data, want.cell_data);
                    if (o_cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", o_cursor_col, want.cursor_col);
                    if (o_cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", o_cursor_row, want.cursor_row);
                    if (o_scrolled !== want.scrolled)
                        report_mismatch("scrolled", o_scrolled, want.scrolled);
                end
            end
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_write(logic [CODE_W-1:0] code);
        request_queue.push_back('{REQ_WRITE, code, INDEX_W'($urandom_range(2047))});
    endtask

    task automatic queue_read(logic [INDEX_W-1:0] index);
        request_queue.push_back('{REQ_READ, CODE_W'($urandom_range(255)), index});
    endtask

    // Waits until every queued beat has been accepted and every predicted
    // result has come back, so the console is idle. The check is made on
    // the falling edge, once the clocked processes have settled.
    task automatic wait_drained();
        while (request_queue.size() > 0 || i_in_valid || console_results.size() > 0)
            @(negedge i_clk);
    endtask

    // The register is written only while the console is idle, so the
    // predictor can take the new value at once.
    task automatic set_attribute(logic [ATTR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        attribute_now = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Random character codes with the odd newline; reads either anywhere,
    // including past the end of the screen, or in the bottom rows where
    // fresh text and scroll fill are found.
    task automatic queue_random_beats(int unsigned count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(99) < 10)
                    queue_write(NEWLINE_CODE);
                else
                    queue_write(CODE_W'($urandom_range(255)));
            end else if ($urandom_range(99) < 40) begin
                queue_read(INDEX_W'($urandom_range(CELL_COUNT - 1,
                                                   CELL_COUNT - 3 * COLUMNS)));
            end else begin
                queue_read(INDEX_W'($urandom_range(2047)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, a directed opening, then random phases with a
    // new attribute value in each. Each phase boundary holds the sender
    // back until every result is in.
    // ------------------------------------------------------------------
    initial begin
        logic [ATTR_W-1:0] phase_attr [6];

        for (int i = 0; i < CELL_COUNT; i++)
            screen_image[i] = RESET_CELL;
        cursor_col_now = 0;
        cursor_row_now = 0;
        attribute_now  = RESET_ATTR;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening, under the reset attribute: reset contents at
        // both ends of the screen, reads just past and far past the end,
        // the lowest and the high character codes, then read-back.
        queue_read(0);
        queue_read(INDEX_W'(CELL_COUNT - 1));
        queue_read(INDEX_W'(CELL_COUNT));
        queue_read(11'h7FF);
        queue_write(8'h00);
        queue_write(8'hFF);
        queue_write(8'h80);
        queue_write(8'h7F);
        queue_write(NEWLINE_CODE);
        queue_write(8'h41);
        queue_read(0);
        queue_read(1);
        queue_read(2);
        queue_read(3);
        queue_read(INDEX_W'(COLUMNS));
        queue_write(NEWLINE_CODE);
        queue_write(NEWLINE_CODE);
        queue_read(INDEX_W'(2 * COLUMNS));
        wait_drained();

        phase_attr = '{8'h00, 8'hFF, ATTR_W'($urandom_range(255)), 8'hA5,
                       ATTR_W'($urandom_range(255)), RESET_ATTR};
        for (int p = 0; p < 6; p++) begin
            set_attribute(phase_attr[p]);
            // The fourth phase runs without any idling on either side.
            idle_pct = (p == 3) ? 0 : 7;
            queue_random_beats(250);
            wait_drained();
        end

        // Everything is in; give a late, stray beat time to show itself.
        repeat (200) @(posedge i_clk);
        if (console_results.size() != 0)
            report_mismatch("results never delivered", 0, console_results.size());

        if (mismatch_count == 0)
            $display("text_console_writer_test: PASS");
        else
            $display("text_console_writer_test: FAIL");
        $finish;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("text_console_writer_test: FAIL");
        $finish;
    end

endmodule
